[hdl/btb_pkg.sv]
package btb_pkg;

    localparam int ENTRIES = 1024;
    localparam int PC_W    = 24;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = 32;
    localparam int OUT_W   = 3;

    // Outcome codes of one result beat.
    localparam logic [OUT_W-1:0] OUT_HIT_NT    = 3'd0;
    localparam logic [OUT_W-1:0] OUT_HIT_RIGHT = 3'd1;
    localparam logic [OUT_W-1:0] OUT_HIT_WRONG = 3'd2;
    localparam logic [OUT_W-1:0] OUT_MISS_ALLOC = 3'd3;
    localparam logic [OUT_W-1:0] OUT_MISS_NT   = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic eval;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic pend_valid;
        logic out_free;
    } t_status;

endpackage

[hdl/btb_ctrl.sv]
module btb_ctrl import btb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_stall,
    output t_cmd    o_cmd
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EVAL  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_in_stall     = 1'b1;
        o_cmd.clear_wr = 1'b0;
        o_cmd.accept   = 1'b0;
        o_cmd.eval     = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
                // The first beat after reset only primes the held pc.
                if (i_in_valid && i_status.pend_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_status.out_free) begin
                    o_cmd.eval = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

[hdl/btb_dpath.sv]
module btb_dpath import btb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic [PC_W-1:0]  i_pc,
    input  logic             i_out_stall,
    output t_status          o_status,
    output logic             o_out_valid,
    output logic             o_was_hit,
    output logic [OUT_W-1:0] o_outcome,
    output logic [CNT_W-1:0] o_hit_count,
    output logic [CNT_W-1:0] o_miss_count,
    output logic [CNT_W-1:0] o_right_count,
    output logic [CNT_W-1:0] o_wrong_count
);

    typedef struct packed {
        logic            valid;
        logic [PC_W-1:0] tag;
        logic [PC_W-1:0] target;
        logic [1:0]      state;
    } t_entry;

    localparam logic [IDX_W-1:0] PART_MASK = IDX_W'(ENTRIES / 2);
    localparam logic [CNT_W-1:0] CNT_MAX   = '1;

    t_entry r_mem [ENTRIES];
    t_entry r_rd_home;
    t_entry r_rd_part;

    logic [IDX_W-1:0] r_clr_idx;
    logic             r_pend_valid;
    logic [PC_W-1:0]  r_pend_pc;
    logic [PC_W-1:0]  r_new_pc;
    logic             r_out_valid;
    logic             r_was_hit;
    logic [OUT_W-1:0] r_outcome;
    logic [CNT_W-1:0] r_hit_cnt;
    logic [CNT_W-1:0] r_miss_cnt;
    logic [CNT_W-1:0] r_right_cnt;
    logic [CNT_W-1:0] r_wrong_cnt;

    logic [IDX_W-1:0] home_idx;
    logic [IDX_W-1:0] part_idx;
    logic             hit;
    logic             fall;
    logic             home_ok;
    logic             wr_en;
    t_entry           wr_data;
    logic [OUT_W-1:0] n_outcome;

    assign home_idx = r_pend_pc[IDX_W+1:2];
    assign part_idx = home_idx ^ PART_MASK;

    assign hit = (r_rd_home.valid && r_rd_home.tag == r_pend_pc) ||
                 (r_rd_part.valid && r_rd_part.tag == r_pend_pc);
    assign fall = {1'b0, r_new_pc} == ({1'b0, r_pend_pc} + (PC_W + 1)'(4));
    assign home_ok = r_rd_home.valid;

    always_comb begin
        wr_data   = r_rd_home;
        wr_en     = 1'b0;
        n_outcome = OUT_MISS_NT;
        if (hit) begin
            wr_en = 1'b1;
            if (fall) begin
                n_outcome = OUT_HIT_NT;
                if (!home_ok) begin
                    wr_data.state = 2'd3;
                end else if (r_rd_home.state != 2'd3) begin
                    wr_data.state = r_rd_home.state + 2'd1;
                end
            end else if (home_ok && r_rd_home.target == r_new_pc) begin
                n_outcome = OUT_HIT_RIGHT;
                if (r_rd_home.state != 2'd0) begin
                    wr_data.state = r_rd_home.state - 2'd1;
                end
            end else begin
                n_outcome      = OUT_HIT_WRONG;
                wr_data.target = r_new_pc;
            end
        end else if (!fall) begin
            wr_en     = 1'b1;
            n_outcome = OUT_MISS_ALLOC;
            wr_data   = '{valid: 1'b1, tag: r_pend_pc, target: r_new_pc, state: 2'd0};
        end
    end

    // Table: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_wr) begin
            r_mem[r_clr_idx] <= '0;
        end else if (i_cmd.eval && wr_en) begin
            r_mem[home_idx] <= wr_data;
        end
        r_rd_home <= r_mem[home_idx];
        r_rd_part <= r_mem[part_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx    <= '0;
            r_pend_valid <= 1'b0;
            r_pend_pc    <= '0;
            r_out_valid  <= 1'b0;
            r_hit_cnt    <= '0;
            r_miss_cnt   <= '0;
            r_right_cnt  <= '0;
            r_wrong_cnt  <= '0;
        end else begin
            if (i_cmd.clear_wr) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (i_cmd.accept && !r_pend_valid) begin
                r_pend_valid <= 1'b1;
                r_pend_pc    <= i_pc;
            end
            if (i_cmd.eval) begin
                r_pend_pc   <= r_new_pc;
                r_out_valid <= 1'b1;
                if (hit && r_hit_cnt != CNT_MAX) begin
                    r_hit_cnt <= r_hit_cnt + 1'b1;
                end
                if (n_outcome == OUT_MISS_ALLOC && r_miss_cnt != CNT_MAX) begin
                    r_miss_cnt <= r_miss_cnt + 1'b1;
                end
                if (n_outcome == OUT_HIT_RIGHT && r_right_cnt != CNT_MAX) begin
                    r_right_cnt <= r_right_cnt + 1'b1;
                end
                if ((n_outcome == OUT_HIT_NT || n_outcome == OUT_HIT_WRONG) &&
                    r_wrong_cnt != CNT_MAX) begin
                    r_wrong_cnt <= r_wrong_cnt + 1'b1;
                end
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_new_pc <= i_pc;
        end
        if (i_cmd.eval) begin
            r_was_hit <= hit;
            r_outcome <= n_outcome;
        end
    end

    assign o_status.clear_last = &r_clr_idx;
    assign o_status.pend_valid = r_pend_valid;
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid   = r_out_valid;
    assign o_was_hit     = r_was_hit;
    assign o_outcome     = r_outcome;
    assign o_hit_count   = r_hit_cnt;
    assign o_miss_count  = r_miss_cnt;
    assign o_right_count = r_right_cnt;
    assign o_wrong_count = r_wrong_cnt;

endmodule

[hdl/branch_target_buffer.sv]
// Result: once the pc beat resolving the held pc is accepted, the evaluate state
// registers the result beat as soon as the output register is free.
// Pacing: no pc beat is accepted in the evaluate state; each beat takes the table
// read in the idle state, then the evaluate-and-write step on the single write port.
// Reset: synchronous, active low; afterwards a clearing pass sweeps all ENTRIES (1024)
// table entries while the input is stalled. Counters and the held pc reset to zero.
module branch_target_buffer import btb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [PC_W-1:0]  i_pc,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_was_hit,
    output logic [OUT_W-1:0] o_outcome,
    output logic [CNT_W-1:0] o_hit_count,
    output logic [CNT_W-1:0] o_miss_count,
    output logic [CNT_W-1:0] o_right_count,
    output logic [CNT_W-1:0] o_wrong_count
);

    // The controller sequences the clearing pass, the accept of each pc beat
    // and the evaluate cycle. The datapath holds the table, the held pc, the
    // statistics counters and the output register.
    t_cmd    cmd;
    t_status status;

    btb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // The table is read every cycle at the home and partner index of the held
    // pc. The held pc and the table change only on an evaluate cycle, priming
    // and clearing apart, so the read data is current in the evaluate state.
    // The output register lets the next pc beat in while a result beat still waits.
    btb_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_pc          (i_pc),
        .i_out_stall   (i_out_stall),
        .o_status      (status),
        .o_out_valid   (o_out_valid),
        .o_was_hit     (o_was_hit),
        .o_outcome     (o_outcome),
        .o_hit_count   (o_hit_count),
        .o_miss_count  (o_miss_count),
        .o_right_count (o_right_count),
        .o_wrong_count (o_wrong_count)
    );

endmodule

[hdl/btb_checker.sv]
module btb_props import btb_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic             o_was_hit,
    input logic [OUT_W-1:0] o_outcome,
    input logic [CNT_W-1:0] o_hit_count,
    input logic [CNT_W-1:0] o_right_count
);

    // A stalled result beat holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_outcome)
            && $stable(o_hit_count))
        else $error("stalled result beat changed");

    // The hit flag agrees with the outcome code.
    a_hit_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_was_hit == (o_outcome == OUT_HIT_NT ||
            o_outcome == OUT_HIT_RIGHT || o_outcome == OUT_HIT_WRONG)))
        else $error("hit flag and outcome disagree");

    // Every right prediction is also a hit.
    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_hit_count >= o_right_count)
        else $error("right count exceeds hit count");

    // The clearing pass keeps the input stalled right after reset.
    a_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input open during clearing pass");

endmodule

bind branch_target_buffer btb_props u_btb_props (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_was_hit     (o_was_hit),
    .o_outcome     (o_outcome),
    .o_hit_count   (o_hit_count),
    .o_right_count (o_right_count)
);
